// ===== rtl/core/positional_list_table_macros.svh =====
// Assertion shorthands used by the list table RTL.
`ifndef POSITIONAL_LIST_TABLE_MACROS_SVH
`define POSITIONAL_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/plt_pkg.sv =====
package plt_pkg;

	localparam int CAPACITY_DEF = 256;

	// Operation codes
	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]          operation;
		logic [8:0]          position;
		logic signed [31:0]  value;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  read_value;
		logic [8:0]          list_length;
		logic                list_empty;
		logic signed [31:0]  first_value;
		logic signed [31:0]  last_value;
	} rsp_t;

	// Broadcast controls seen by every cell
	typedef struct packed {
		logic ins;      // shift up from the insert point
		logic del;      // shift down into the deleted slot
		logic set;      // overwrite the addressed slot
		logic load;     // capture masked read taps
		logic shift;    // move read taps toward cell 0
		logic get_en;   // get tap is live
		logic last_en;  // tail tap is live
	} cell_ctrl_t;

endpackage

// ===== rtl/core/plt_cell.sv =====
module plt_cell #(
	parameter int CAPACITY = plt_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                          clk,
	input  plt_pkg::cell_ctrl_t           ctrl,
	input  logic [$clog2(CAPACITY)-1:0]   at_idx,
	input  logic [$clog2(CAPACITY)-1:0]   get_idx,
	input  logic [$clog2(CAPACITY)-1:0]   last_idx,
	input  logic signed [31:0]            ins_value,
	input  logic signed [31:0]            left_val,
	input  logic signed [31:0]            right_val,
	input  logic signed [31:0]            right_cap,
	input  logic signed [31:0]            right_last,
	output logic signed [31:0]            val,
	output logic signed [31:0]            cap,
	output logic signed [31:0]            lst
);
	import plt_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [31:0] val_q;
	logic signed [31:0] cap_q;
	logic signed [31:0] lst_q;

	// Update the stored entry from the broadcast operation
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX == at_idx) begin
				val_q <= ins_value;
			end else if (MY_IDX > at_idx) begin
				val_q <= left_val;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= at_idx) begin
				val_q <= right_val;
			end
		end else if (ctrl.set) begin
			if (MY_IDX == at_idx) begin
				val_q <= ins_value;
			end
		end
	end

	// Load masked taps, then fold them toward cell 0
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cap_q <= (ctrl.get_en && MY_IDX == get_idx) ? val_q : 32'sd0;
			lst_q <= (ctrl.last_en && MY_IDX == last_idx) ? val_q : 32'sd0;
		end else if (ctrl.shift) begin
			cap_q <= cap_q | right_cap;
			lst_q <= lst_q | right_last;
		end
	end

	assign val = val_q;
	assign cap = cap_q;
	assign lst = lst_q;

endmodule

// ===== rtl/core/positional_list_table.sv =====
// Positional list table: an ordered list of up to CAPACITY signed 32-bit
// entries held in a row of cells, one entry per cell. Insert, delete and set
// take effect in the cycle the request transfers, every cell shifting at
// once. The result (read value and tail value) is then gathered by a tap
// chain that folds toward cell 0, one cell per cycle, and a new request is
// taken once that sweep is done and the output register has taken its
// result. The finished result sits in an output register, so the next
// request may transfer while it still waits to be taken.
`include "positional_list_table_macros.svh"

module positional_list_table #(
	parameter int CAPACITY = plt_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  plt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output plt_pkg::rsp_t rsp
);
	import plt_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 10) ? CW : 10;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    sweep_q;
	logic [1:0]       status_q;
	logic             get_q;
	logic [IW-1:0]    gsel_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic [CMPW-1:0]  pos_w;
	logic [CMPW-1:0]  cnt_w;
	logic [CMPW-1:0]  at_w;
	logic [IW-1:0]    at_idx;
	logic [IW-1:0]    last_idx;
	logic             ins_ok, del_ok, get_ok, set_ok, clr;
	logic [1:0]       status_d;
	logic             finish;
	logic             slot_free;
	cell_ctrl_t       ctrl;

	logic signed [31:0] val [CAPACITY];
	logic signed [31:0] cap [CAPACITY];
	logic signed [31:0] lst [CAPACITY];

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign pos_w     = CMPW'(req.position);
	assign cnt_w     = CMPW'(cnt_q);
	assign at_w      = pos_w - CMPW'(1);
	assign at_idx    = at_w[IW-1:0];
	assign last_idx  = IW'(cnt_w - CMPW'(1));

	// Decode the request and check its position
	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		get_ok   = 1'b0;
		set_ok   = 1'b0;
		clr      = 1'b0;
		status_d = ST_OK;
		case (req.operation)
			OP_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
					status_d = ST_RANGE;
				end else if (cnt_w == CMPW'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			OP_DELETE, OP_GET, OP_SET: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					status_d = ST_RANGE;
				end else begin
					del_ok = (req.operation == OP_DELETE);
					get_ok = (req.operation == OP_GET);
					set_ok = (req.operation == OP_SET);
				end
			end
			OP_CLEAR: clr = 1'b1;
			default:  status_d = ST_OK;
		endcase
	end

	// Broadcast controls to the cell row
	always_comb begin
		ctrl.ins     = accept && ins_ok;
		ctrl.del     = accept && del_ok;
		ctrl.set     = accept && set_ok;
		ctrl.load    = (state_q == S_LOAD);
		ctrl.shift   = (state_q == S_SWEEP);
		ctrl.get_en  = get_q;
		ctrl.last_en = (cnt_q != '0);
	end

	// Cell row: neighbors wired left and right, tap chain folds to cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_v;
		logic signed [31:0] right_v;
		logic signed [31:0] right_c;
		logic signed [31:0] right_l;

		if (i == 0) begin : g_first
			assign left_v = 32'sd0;
		end else begin : g_mid_l
			assign left_v = val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = 32'sd0;
			assign right_c = 32'sd0;
			assign right_l = 32'sd0;
		end else begin : g_mid_r
			assign right_v = val[i+1];
			assign right_c = cap[i+1];
			assign right_l = lst[i+1];
		end

		plt_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.at_idx     (at_idx),
			.get_idx    (gsel_q),
			.last_idx   (last_idx),
			.ins_value  (req.value),
			.left_val   (left_v),
			.right_val  (right_v),
			.right_cap  (right_c),
			.right_last (right_l),
			.val        (val[i]),
			.cap        (cap[i]),
			.lst        (lst[i])
		);
	end

	assign finish    = ((state_q == S_SWEEP) && (sweep_q == IW'(CAPACITY - 1)))
	                   || (state_q == S_HOLD);
	assign slot_free = !rsp_valid_q || rsp_ready;

	// Sequence apply, tap load, sweep and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sweep_q     <= '0;
			get_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (ins_ok) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (del_ok) begin
							cnt_q <= cnt_q - CW'(1);
						end else if (clr) begin
							cnt_q <= '0;
						end
						get_q   <= get_ok;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					sweep_q <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP, S_HOLD: begin
					sweep_q <= sweep_q + IW'(1);
					if (finish) begin
						if (slot_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Raise the result valid on a finished sweep, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold request payload for the result
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			gsel_q   <= at_idx;
		end
	end

	// Capture the result once the taps reach cell 0
	always_ff @(posedge clk) begin
		if (finish && slot_free) begin
			rsp_q.status      <= status_q;
			rsp_q.read_value  <= cap[0];
			rsp_q.list_length <= 9'(cnt_q);
			rsp_q.list_empty  <= (cnt_q == '0);
			rsp_q.first_value <= (cnt_q != '0) ? val[0] : 32'sd0;
			rsp_q.last_value  <= lst[0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PLT_ASSERT_NEXT(a_accept_loads, accept, state_q == S_LOAD, "transfer did not start a load")
	`PLT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`PLT_ASSERT_IMPL(a_hold_pending, state_q == S_HOLD, rsp_valid_q, "hold without pending result")
	`PLT_ASSERT_IMPL(a_empty_zero, rsp_valid_q && rsp_q.list_empty,
		rsp_q.first_value == 32'sd0 && rsp_q.last_value == 32'sd0, "empty list with values")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	import plt_pkg::*;

	localparam int CAP           = CAPACITY_DEF;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 1575;
	localparam int PRINT_LIMIT    = 30;

	// Spare operation codes: accepted, change nothing, report ok
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int sent              = 0;
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;

	// Shadow copy of the list; predicts the response of every transfer
	class list_mirror;
		logic signed [31:0] slots[CAP];
		int                 fill_level;
		rsp_t               awaited_rsp[$];
		int                 mismatches;
		int                 checked;
		int                 range_rejects;
		int                 full_rejects;
		int                 peak_level;
		int                 op_seen[8];

		function new();
			fill_level    = 0;
			mismatches    = 0;
			checked       = 0;
			range_rejects = 0;
			full_rejects  = 0;
			peak_level    = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
		endfunction

		// Apply one accepted request and queue its response
		function void note_request(req_t r);
			rsp_t e;
			int   pos;
			pos = r.position;
			e = '0;
			e.status = ST_OK;
			op_seen[r.operation]++;
			case (r.operation)
				OP_INSERT: begin
					if (pos < 1 || pos > fill_level + 1) begin
						e.status = ST_RANGE;
					end else if (fill_level >= CAP) begin
						e.status = ST_FULL;
					end else begin
						for (int i = fill_level; i > pos - 1; i--) slots[i] = slots[i - 1];
						slots[pos - 1] = r.value;
						fill_level++;
					end
				end
				OP_DELETE: begin
					if (pos < 1 || pos > fill_level) begin
						e.status = ST_RANGE;
					end else begin
						for (int i = pos - 1; i < fill_level - 1; i++) slots[i] = slots[i + 1];
						fill_level--;
					end
				end
				OP_GET: begin
					if (pos < 1 || pos > fill_level) e.status = ST_RANGE;
					else e.read_value = slots[pos - 1];
				end
				OP_SET: begin
					if (pos < 1 || pos > fill_level) e.status = ST_RANGE;
					else slots[pos - 1] = r.value;
				end
				OP_CLEAR: begin
					fill_level = 0;
				end
				default: begin
				end
			endcase
			e.list_length = 9'(fill_level);
			e.list_empty  = (fill_level == 0);
			e.first_value = (fill_level == 0) ? '0 : slots[0];
			e.last_value  = (fill_level == 0) ? '0 : slots[fill_level - 1];
			if (e.status == ST_RANGE) range_rejects++;
			if (e.status == ST_FULL) full_rejects++;
			if (fill_level > peak_level) peak_level = fill_level;
			awaited_rsp.push_back(e);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		// Compare one accepted response with the oldest prediction
		task check_response(rsp_t got);
			rsp_t e;
			if (awaited_rsp.size() == 0) begin
				report("response transfer with no request outstanding");
				return;
			end
			e = awaited_rsp.pop_front();
			checked++;
			if (got.status !== e.status)
				report($sformatf("rsp %0d status got %0d want %0d",
					checked, got.status, e.status));
			if (got.read_value !== e.read_value)
				report($sformatf("rsp %0d read_value got %0d want %0d",
					checked, got.read_value, e.read_value));
			if (got.list_length !== e.list_length)
				report($sformatf("rsp %0d list_length got %0d want %0d",
					checked, got.list_length, e.list_length));
			if (got.list_empty !== e.list_empty)
				report($sformatf("rsp %0d list_empty got %0b want %0b",
					checked, got.list_empty, e.list_empty));
			if (got.first_value !== e.first_value)
				report($sformatf("rsp %0d first_value got %0d want %0d",
					checked, got.first_value, e.first_value));
			if (got.last_value !== e.last_value)
				report($sformatf("rsp %0d last_value got %0d want %0d",
					checked, got.last_value, e.last_value));
		endtask
	endclass

	list_mirror mirror = new();

	positional_list_table #(
		.CAPACITY(CAP)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Take responses, stall at random
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) mirror.check_response(rsp);
		rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Hold off a random gap, then present the request until it transfers
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		mirror.note_request(r);
		sent++;
	endtask

	task automatic send_op(input logic [2:0] op, input logic [8:0] pos,
			input logic signed [31:0] val);
		req_t r;
		r.operation = op;
		r.position  = pos;
		r.value     = val;
		send_request(r);
	endtask

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in range, with zero, just past the end and far beyond mixed in
	function automatic logic [8:0] pick_position(input logic [2:0] op, input int level);
		int top;
		top = (op == OP_INSERT) ? level + 1 : level;
		case ($urandom_range(11))
			0: return 9'd0;
			1: return 9'(top + 1);
			2: return 9'($urandom_range(511, top + 1));
			3: return 9'h1FF;
			4: return 9'(top);
			default: return (top == 0) ? 9'd1 : 9'($urandom_range(top, 1));
		endcase
	endfunction

	function automatic logic [2:0] pick_operation();
		int r;
		r = $urandom_range(99);
		if (r < 38) return OP_INSERT;
		if (r < 64) return OP_DELETE;
		if (r < 80) return OP_GET;
		if (r < 92) return OP_SET;
		if (r < 95) return OP_CLEAR;
		case ($urandom_range(2))
			0: return OP_SPARE_A;
			1: return OP_SPARE_B;
			default: return OP_SPARE_C;
		endcase
	endfunction

	task automatic send_random(input logic [2:0] op);
		send_op(op, pick_position(op, mirror.fill_level), random_value());
	endtask

	// Grow to capacity, probe the full store, then empty it again
	task automatic fill_store();
		while (mirror.fill_level < CAP) begin
			if ($urandom_range(7) == 0) send_random(OP_GET);
			else send_op(OP_INSERT, 9'($urandom_range(mirror.fill_level + 1, 1)),
				random_value());
		end
		send_op(OP_INSERT, 9'd1, random_value());
		send_op(OP_INSERT, 9'(CAP + 1), random_value());
		send_op(OP_INSERT, 9'($urandom_range(CAP, 2)), random_value());
		send_op(OP_INSERT, 9'd0, random_value());
		send_op(OP_INSERT, 9'(CAP + 2), random_value());
		send_op(OP_INSERT, 9'h1FF, random_value());
		send_op(OP_GET, 9'(CAP), '0);
		send_op(OP_SET, 9'(CAP), random_value());
		send_op(OP_GET, 9'd1, '0);
		send_op(OP_DELETE, 9'($urandom_range(CAP, 1)), '0);
		send_op(OP_INSERT, 9'($urandom_range(CAP, 1)), random_value());
		send_op(OP_INSERT, 9'(CAP + 1), random_value());
		send_op(OP_DELETE, 9'(CAP), '0);
		send_op(OP_DELETE, 9'd1, '0);
		send_op(OP_GET, 9'(CAP), '0);
		send_op(OP_CLEAR, 9'($urandom_range(511)), random_value());
	endtask

	// Random bursts: mixed, growing, draining, plus the odd clear
	task automatic run_phase(input int target, input bit with_fill);
		int n;
		if (with_fill) fill_store();
		while (sent < target) begin
			n = $urandom_range(40, 10);
			case ($urandom_range(9))
				6, 7: repeat (n) begin
					if ($urandom_range(7) == 0) send_random(OP_GET);
					else send_random(OP_INSERT);
				end
				8: repeat (n) begin
					if ($urandom_range(3) == 0) send_random(OP_GET);
					else send_random(OP_DELETE);
				end
				9: send_random(OP_CLEAR);
				default: repeat (n) send_random(pick_operation());
			endcase
		end
	endtask

	initial begin
		sender_idle_pct   = 23;
		receiver_idle_pct = 54;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every positional access is out of range
		send_op(OP_GET, 9'd1, '0);
		send_op(OP_DELETE, 9'd1, '0);
		send_op(OP_SET, 9'd1, 32'sh1234_5678);
		send_op(OP_INSERT, 9'd0, 32'sh1111_1111);
		send_op(OP_INSERT, 9'd2, 32'sh2222_2222);
		// Build four entries at head, tail and middle
		send_op(OP_INSERT, 9'd1, 32'sh8000_0000);
		send_op(OP_INSERT, 9'd2, 32'sh7FFF_FFFF);
		send_op(OP_INSERT, 9'd1, -32'sd1);
		send_op(OP_INSERT, 9'd2, '0);
		// Position zero, the last entry and beyond the end
		send_op(OP_GET, 9'd0, '0);
		send_op(OP_SET, 9'd0, 32'sh5555_5555);
		send_op(OP_DELETE, 9'd0, '0);
		send_op(OP_GET, 9'd4, '0);
		send_op(OP_GET, 9'd5, '0);
		send_op(OP_SET, 9'd4, 32'sh5555_5555);
		send_op(OP_INSERT, 9'h1FF, 32'shAAAA_AAAA);
		send_op(OP_GET, 9'h1FF, '0);
		// Spare codes do nothing
		send_op(OP_SPARE_A, 9'd1, 32'sh0F0F_0F0F);
		send_op(OP_SPARE_B, 9'd2, 32'shF0F0_F0F0);
		send_op(OP_SPARE_C, 9'h1FF, -32'sd1);
		// Drop tail and head, overwrite, then clear twice
		send_op(OP_DELETE, 9'd4, '0);
		send_op(OP_DELETE, 9'd1, '0);
		send_op(OP_SET, 9'd1, 32'sh2AAA_AAAA);
		send_op(OP_CLEAR, 9'd3, '0);
		send_op(OP_CLEAR, 9'h1FF, -32'sd1);

		run_phase(DIRECTED_ITEMS + RANDOM_ITEMS / 3, 1'b1);
		sender_idle_pct   = 54;
		receiver_idle_pct = 23;
		run_phase(DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3, 1'b0);
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		run_phase(DIRECTED_ITEMS + RANDOM_ITEMS, 1'b1);
		req_valid <= 1'b0;

		// Drain outstanding responses, then allow one more sweep
		while (mirror.awaited_rsp.size() != 0) @(posedge clk);
		repeat (CAP + 16) @(posedge clk);

		$display("Ran %0d requests: %0d insert, %0d delete, %0d get, %0d set, %0d clear, %0d spare;",
			sent, mirror.op_seen[OP_INSERT], mirror.op_seen[OP_DELETE],
			mirror.op_seen[OP_GET], mirror.op_seen[OP_SET], mirror.op_seen[OP_CLEAR],
			mirror.op_seen[OP_SPARE_A] + mirror.op_seen[OP_SPARE_B]
			+ mirror.op_seen[OP_SPARE_C]);
		$display("%0d responses checked, %0d range and %0d full rejects, deepest list %0d of %0d.",
			mirror.checked, mirror.range_rejects, mirror.full_rejects,
			mirror.peak_level, CAP);
		if (mirror.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/plt_pkg.sv
rtl/core/plt_cell.sv
rtl/core/positional_list_table.sv
bench/testbench.sv
